// ===== sv/mku_pkg.sv =====
// shared types, constants and helpers of the mecanum kinematics unit
package mku_pkg;

   localparam int DATA_W            = 32;
   localparam int OP_W              = 2;
   localparam int CSR_IDX_W         = 2;
   localparam int NUM_WHEELS        = 4;
   localparam int NUM_AXES          = 3;
   localparam int LANE_LAT          = 4;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int SAT_W             = 128;

   localparam logic [OP_W-1:0] OP_INVERSE = 2'd0;
   localparam logic [OP_W-1:0] OP_FORWARD = 2'd1;
   localparam logic [OP_W-1:0] OP_SLIP    = 2'd2;
   localparam logic [OP_W-1:0] OP_CONSIST = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_INVERSE_RADIUS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QUARTER_RADIUS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEVER_SUM       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_QUARTER_PER_LEV = 2'd3;

   localparam logic [DATA_W-1:0] INVERSE_RADIUS_RESET  = 32'd1310720;
   localparam logic [DATA_W-1:0] QUARTER_RADIUS_RESET  = 32'd819;
   localparam logic [DATA_W-1:0] LEVER_SUM_RESET       = 32'd22938;
   localparam logic [DATA_W-1:0] QUARTER_PER_LEV_RESET = 32'd2341;

   localparam logic signed [SAT_W-1:0] SAT_MAX = {{(SAT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_MIN = {{(SAT_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              clip;
   } sat_type;

   typedef struct packed {
      logic [OP_W-1:0]                       op;
      logic [DATA_W-1:0]                     twist_vx;
      logic [DATA_W-1:0]                     twist_vy;
      logic [DATA_W-1:0]                     twist_wz;
      logic [NUM_WHEELS-1:0][DATA_W-1:0]     wheel;
      logic [NUM_AXES-1:0][DATA_W-1:0]       body;
      logic [NUM_WHEELS-1:0][DATA_W-1:0]     wheel_out;
      logic [DATA_W-1:0]                     consistency;
      logic                                  saturated;
   } pipe_type;

   function automatic sat_type sat32(input logic signed [SAT_W-1:0] v);
      sat_type r;
      r.value = v[DATA_W-1:0];
      r.clip  = 1'b0;
      if (v > SAT_MAX) begin
         r.value = {1'b0, {(DATA_W-1){1'b1}}};
         r.clip  = 1'b1;
      end else if (v < SAT_MIN) begin
         r.value = {1'b1, {(DATA_W-1){1'b0}}};
         r.clip  = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== sv/mku_mul_lane.sv =====
// pipelined signed by unsigned fixed point multiply lane with round to nearest
module mku_mul_lane #(
   parameter int A_W       = 34,
   parameter int FRAC_BITS = mku_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic [mku_pkg::LANE_LAT-1:0]       en,
   input  logic signed [A_W-1:0]              a,
   input  logic [mku_pkg::DATA_W-1:0]         coef,
   output logic signed [A_W+mku_pkg::DATA_W-FRAC_BITS:0] y
);
   import mku_pkg::*;

   localparam int HI_W   = A_W - DATA_W;
   localparam int LO_P_W = 2 * DATA_W;
   localparam int HI_P_W = HI_W + DATA_W;
   localparam int PROD_W = A_W + DATA_W;
   localparam int RND_W  = PROD_W - FRAC_BITS;
   localparam int OUT_W  = RND_W + 1;

   logic                 neg1_ff, neg2_ff, neg3_ff;
   logic [A_W-1:0]       mag_in, mag_ff;
   logic [LO_P_W-1:0]    plo_in, plo_ff;
   logic [HI_P_W-1:0]    phi_in, phi_ff;
   logic [PROD_W-1:0]    sum;
   logic [RND_W-1:0]     rnd_in, rnd_ff;
   logic signed [OUT_W-1:0] y_in, y_ff;

   assign mag_in = a[A_W-1] ? A_W'(-a) : A_W'(a);
   assign plo_in = LO_P_W'(mag_ff[DATA_W-1:0]) * LO_P_W'(coef);
   assign phi_in = HI_P_W'(mag_ff[A_W-1:DATA_W]) * HI_P_W'(coef);
   assign sum    = PROD_W'(plo_ff) + (PROD_W'(phi_ff) << DATA_W)
                 + (PROD_W'(1) << (FRAC_BITS - 1));
   assign rnd_in = sum[PROD_W-1:FRAC_BITS];
   assign y_in   = neg3_ff ? -$signed({1'b0, rnd_ff}) : $signed({1'b0, rnd_ff});
   assign y      = y_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg1_ff <= a[A_W-1];
         mag_ff  <= mag_in;
      end
      if (en[1]) begin
         neg2_ff <= neg1_ff;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
      end
      if (en[2]) begin
         neg3_ff <= neg2_ff;
         rnd_ff  <= rnd_in;
      end
      if (en[3]) begin
         y_ff <= y_in;
      end
   end

endmodule

// ===== sv/mecanum_kinematics_unit.sv =====
// mecanum kinematics unit: lane-parallel forward, inverse, slip and consistency pipeline
// an item passes the input, forward, twist, inverse and output stages before rsp_tvalid
// throughput: one item per cycle unless rsp_tready stalls, set by the fully pipelined four-stage multiply lanes
// each stage advances when it is empty or the stage after it advances, so bubbles close up
// reset: clears all stage valid bits and loads the geometry registers with their defaults
// payload registers are not reset
module mecanum_kinematics_unit #(
   parameter int FRAC_BITS = mku_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // twist_vx, twist_vy, twist_wz, front_left_in, front_right_in, rear_left_in, rear_right_in
   input  logic [7*mku_pkg::DATA_W-1:0]           req_tdata,
   // op
   input  logic [mku_pkg::OP_W-1:0]               req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // body_vx, body_vy, body_wz, front_left_out, front_right_out, rear_left_out,
   // rear_right_out, consistency
   output logic [8*mku_pkg::DATA_W-1:0]           rsp_tdata,
   // saturated
   output logic [0:0]                             rsp_tuser,
   input  logic                                   csr_we,
   input  logic [mku_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [mku_pkg::DATA_W-1:0]             csr_wdata
);
   import mku_pkg::*;

   localparam int ST_IN    = 0;
   localparam int ST_FSUM  = ST_IN + 1;
   localparam int ST_TWIST = ST_FSUM + LANE_LAT + 1;
   localparam int ST_ISUM  = ST_TWIST + LANE_LAT + 1;
   localparam int ST_OUT   = ST_ISUM + LANE_LAT + 1;
   localparam int NUM_ST   = ST_OUT + 1;

   localparam int FSUM_W = DATA_W + 2;
   localparam int FWD_OW = FSUM_W + DATA_W - FRAC_BITS + 1;
   localparam int LW_AW  = DATA_W + 1;
   localparam int LW_OW  = LW_AW + DATA_W - FRAC_BITS + 1;
   localparam int INV_AW = LW_OW + 2;
   localparam int INV_OW = INV_AW + DATA_W - FRAC_BITS + 1;

   logic [DATA_W-1:0] inv_radius_ff, quarter_radius_ff, lever_sum_ff, quarter_per_lev_ff;

   logic [NUM_ST-1:0] en;
   logic [NUM_ST-1:0] valid_ff, valid_in;
   pipe_type          pipe_ff [NUM_ST];
   pipe_type          pipe_in [NUM_ST];

   logic signed [FSUM_W-1:0] fsum_in [NUM_AXES];
   logic signed [FSUM_W-1:0] fsum_ff [NUM_AXES];
   logic signed [FWD_OW-1:0] fwd_y   [NUM_AXES];
   logic signed [LW_OW-1:0]  lw_y;
   logic signed [INV_AW-1:0] isum_in [NUM_WHEELS];
   logic signed [INV_AW-1:0] isum_ff [NUM_WHEELS];
   logic signed [INV_OW-1:0] inv_y   [NUM_WHEELS];

   // geometry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_radius_ff      <= INVERSE_RADIUS_RESET;
         quarter_radius_ff  <= QUARTER_RADIUS_RESET;
         lever_sum_ff       <= LEVER_SUM_RESET;
         quarter_per_lev_ff <= QUARTER_PER_LEV_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_INVERSE_RADIUS:  inv_radius_ff      <= csr_wdata;
            REG_QUARTER_RADIUS:  quarter_radius_ff  <= csr_wdata;
            REG_LEVER_SUM:       lever_sum_ff       <= csr_wdata;
            REG_QUARTER_PER_LEV: quarter_per_lev_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // stage advance chain
   always_comb begin
      en[NUM_ST-1] = !valid_ff[NUM_ST-1] || rsp_tready;
      for (int i = NUM_ST - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = req_tvalid;
      for (int i = 1; i < NUM_ST; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_ST; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // forward sums
   always_comb begin
      logic signed [FSUM_W-1:0] w [NUM_WHEELS];
      for (int k = 0; k < NUM_WHEELS; k++) begin
         w[k] = FSUM_W'($signed(pipe_ff[ST_IN].wheel[k]));
      end
      fsum_in[0] =  w[0] + w[1] + w[2] + w[3];
      fsum_in[1] = -w[0] + w[1] + w[2] - w[3];
      fsum_in[2] = -w[0] + w[1] - w[2] + w[3];
   end

   genvar j;
   generate
      for (j = 0; j < NUM_AXES; j++) begin : g_fwd_lane
         mku_mul_lane #(
            .A_W       (FSUM_W),
            .FRAC_BITS (FRAC_BITS)
         ) u_lane (
            .clock (clock),
            .en    (en[ST_FSUM+1 +: LANE_LAT]),
            .a     (fsum_ff[j]),
            .coef  ((j == NUM_AXES - 1) ? quarter_per_lev_ff : quarter_radius_ff),
            .y     (fwd_y[j])
         );
      end
   endgenerate

   mku_mul_lane #(
      .A_W       (LW_AW),
      .FRAC_BITS (FRAC_BITS)
   ) u_lever_lane (
      .clock (clock),
      .en    (en[ST_TWIST+1 +: LANE_LAT]),
      .a     (LW_AW'($signed(pipe_ff[ST_TWIST].twist_wz))),
      .coef  (lever_sum_ff),
      .y     (lw_y)
   );

   // inverse sums
   always_comb begin
      logic signed [INV_AW-1:0] vx, vy, lw;
      vx = INV_AW'($signed(pipe_ff[ST_ISUM-1].twist_vx));
      vy = INV_AW'($signed(pipe_ff[ST_ISUM-1].twist_vy));
      lw = INV_AW'(lw_y);
      isum_in[0] = vx - vy - lw;
      isum_in[1] = vx + vy + lw;
      isum_in[2] = vx + vy - lw;
      isum_in[3] = vx - vy + lw;
   end

   generate
      for (j = 0; j < NUM_WHEELS; j++) begin : g_inv_lane
         mku_mul_lane #(
            .A_W       (INV_AW),
            .FRAC_BITS (FRAC_BITS)
         ) u_lane (
            .clock (clock),
            .en    (en[ST_ISUM+1 +: LANE_LAT]),
            .a     (isum_ff[j]),
            .coef  (inv_radius_ff),
            .y     (inv_y[j])
         );
      end
   endgenerate

   // stage payload, with the twist select and the merge stage
   always_comb begin
      sat_type                  tt [NUM_AXES];
      sat_type                  rec [NUM_WHEELS];
      sat_type                  res [NUM_WHEELS];
      sat_type                  cons_sat;
      logic                     fwd_clip, inv_clip, res_clip;
      logic signed [DATA_W:0]   diff;
      logic signed [FSUM_W-1:0] w [NUM_WHEELS];
      logic signed [FSUM_W-1:0] cons_s, cons_p, cons_h;
      pipe_type                 p;

      pipe_in[0].op          = req_tuser;
      pipe_in[0].twist_vx    = req_tdata[DATA_W-1:0];
      pipe_in[0].twist_vy    = req_tdata[2*DATA_W-1:DATA_W];
      pipe_in[0].twist_wz    = req_tdata[3*DATA_W-1:2*DATA_W];
      pipe_in[0].wheel       = req_tdata[7*DATA_W-1:3*DATA_W];
      pipe_in[0].body        = '0;
      pipe_in[0].wheel_out   = '0;
      pipe_in[0].consistency = '0;
      pipe_in[0].saturated   = 1'b0;
      for (int i = 1; i < NUM_ST; i++) begin
         pipe_in[i] = pipe_ff[i-1];
      end

      // forward results, and the twist that feeds the inverse half
      p = pipe_ff[ST_TWIST-1];
      fwd_clip = 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
         tt[k] = sat32(SAT_W'(fwd_y[k]));
         fwd_clip = fwd_clip | tt[k].clip;
         p.body[k] = (p.op == OP_FORWARD) ? tt[k].value : '0;
      end
      if (p.op != OP_INVERSE) begin
         p.twist_vx = tt[0].value;
         p.twist_vy = tt[1].value;
         p.twist_wz = tt[2].value;
      end
      p.saturated = p.saturated | (fwd_clip & ((p.op == OP_FORWARD) || (p.op == OP_SLIP)));
      pipe_in[ST_TWIST] = p;

      // merge
      p = pipe_ff[ST_OUT-1];
      inv_clip = 1'b0;
      res_clip = 1'b0;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         w[k]     = FSUM_W'($signed(p.wheel[k]));
         rec[k]   = sat32(SAT_W'(inv_y[k]));
         diff     = (DATA_W+1)'($signed(p.wheel[k])) - (DATA_W+1)'($signed(rec[k].value));
         res[k]   = sat32(SAT_W'(diff));
         inv_clip = inv_clip | rec[k].clip;
         res_clip = res_clip | res[k].clip;
      end
      cons_s   = w[0] + w[1] - w[2] - w[3];
      cons_p   = cons_s + FSUM_W'(1);
      cons_h   = cons_s[FSUM_W-1] ? (cons_s >>> 1) : (cons_p >>> 1);
      cons_sat = sat32(SAT_W'(cons_h));
      case (p.op)
         OP_INVERSE: begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
               p.wheel_out[k] = rec[k].value;
            end
            p.saturated = p.saturated | inv_clip;
         end
         OP_SLIP: begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
               p.wheel_out[k] = res[k].value;
            end
            p.saturated = p.saturated | inv_clip | res_clip;
         end
         OP_CONSIST: begin
            p.consistency = cons_sat.value;
            p.saturated   = p.saturated | cons_sat.clip;
         end
         default: begin
         end
      endcase
      pipe_in[ST_OUT] = p;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_ST; i++) begin
         if (en[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
      if (en[ST_FSUM]) begin
         fsum_ff <= fsum_in;
      end
      if (en[ST_ISUM]) begin
         isum_ff <= isum_in;
      end
   end

   assign rsp_tvalid   = valid_ff[ST_OUT];
   assign rsp_tdata    = {pipe_ff[ST_OUT].consistency, pipe_ff[ST_OUT].wheel_out,
                          pipe_ff[ST_OUT].body};
   assign rsp_tuser[0] = pipe_ff[ST_OUT].saturated;

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[ST_IN])
      else $error("transfer in did not reach the input stage");

   a_moves_into_empty_out: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_OUT-1] && !valid_ff[ST_OUT] |=> valid_ff[ST_OUT])
      else $error("item did not move into an empty output stage");

   a_refuse_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> valid_ff[ST_IN] && valid_ff[ST_OUT] && !rsp_tready)
      else $error("input refused while the pipeline could advance");

   a_consist_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (pipe_ff[ST_OUT].op == OP_CONSIST)
         |-> (pipe_ff[ST_OUT].body == '0) && (pipe_ff[ST_OUT].wheel_out == '0))
      else $error("consistency result carries nonzero unused fields");

endmodule
